// ----- rtl/core/sbpms_pkg.sv -----
package sbpms_pkg;

    localparam int unsigned MAX_ELEMENTS_DEF = 32'd16777216;
    localparam int          FRACTION_BITS    = 16;
    localparam int          WORD_W           = 32;

    // result kinds
    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_POS  = 2'd1;
    localparam logic [1:0] KIND_NEG  = 2'd2;

    // fixed scales used when scaling is off
    localparam logic [WORD_W-1:0] PLUS_ONE  = (FRACTION_BITS >= 31) ? 32'h7FFF_FFFF
                                                                    : (32'd1 << FRACTION_BITS);
    localparam logic [WORD_W-1:0] MINUS_ONE = 32'd0 - (32'd1 << FRACTION_BITS);

    // one packed word, optionally closing the tensor
    typedef struct packed {
        logic              is_end;
        logic [WORD_W-1:0] word;
    } t_word_cmd;

    function automatic int cnt_width(input int unsigned max_el);
        return $clog2(max_el + 1);
    endfunction

    // group sums: magnitude up to 2^31 per element
    function automatic int sum_width(input int unsigned max_el);
        return WORD_W - 1 + cnt_width(max_el);
    endfunction

endpackage

// ----- rtl/core/sbpms_front.sv -----
module sbpms_front #(
    parameter int unsigned MAX_ELEMENTS = sbpms_pkg::MAX_ELEMENTS_DEF,
    localparam int CNT_W = sbpms_pkg::cnt_width(MAX_ELEMENTS),
    localparam int SUM_W = sbpms_pkg::sum_width(MAX_ELEMENTS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [31:0]      i_sample,
    input  logic                    i_last,
    input  logic                    i_full,
    output logic                    o_push,
    output sbpms_pkg::t_word_cmd    o_cmd,
    output logic [SUM_W-1:0]        o_nn_sum,
    output logic [SUM_W-1:0]        o_ng_sum,
    output logic [CNT_W-1:0]        o_nn_cnt,
    output logic [CNT_W-1:0]        o_ng_cnt
);

    localparam logic [CNT_W:0] MAX_C = (CNT_W + 1)'(MAX_ELEMENTS);

    logic [31:0]      r_shift, n_shift;
    logic [4:0]       r_held, n_held;
    logic [SUM_W-1:0] r_nn_sum, n_nn_sum, r_ng_sum, n_ng_sum;
    logic [CNT_W-1:0] r_nn_cnt, n_nn_cnt, r_ng_cnt, n_ng_cnt;

    logic             accept, negative, positive, add_ok;
    logic [CNT_W:0]   total;
    logic [31:0]      magnitude;

    assign accept    = i_valid && !i_full;
    assign negative  = i_sample[31];
    assign positive  = !negative && (i_sample != 32'sd0);
    assign total     = {1'b0, r_nn_cnt} + {1'b0, r_ng_cnt};
    assign add_ok    = total < MAX_C;
    assign magnitude = 32'd0 - $unsigned(i_sample);

    always_comb begin
        n_shift  = {r_shift[30:0], positive};
        n_held   = r_held + 5'd1;
        n_nn_sum = r_nn_sum;
        n_ng_sum = r_ng_sum;
        n_nn_cnt = r_nn_cnt;
        n_ng_cnt = r_ng_cnt;
        if (add_ok) begin
            if (negative) begin
                n_ng_sum = r_ng_sum + SUM_W'(magnitude);
                n_ng_cnt = r_ng_cnt + CNT_W'(1);
            end else begin
                n_nn_sum = r_nn_sum + SUM_W'($unsigned(i_sample));
                n_nn_cnt = r_nn_cnt + CNT_W'(1);
            end
        end
    end

    // full word, or a partial one left-aligned at the end of the tensor
    assign o_push      = accept && ((r_held == 5'd31) || i_last);
    assign o_cmd.word  = n_shift << (5'd31 - r_held);
    assign o_cmd.is_end = i_last;
    assign o_nn_sum    = n_nn_sum;
    assign o_ng_sum    = n_ng_sum;
    assign o_nn_cnt    = n_nn_cnt;
    assign o_ng_cnt    = n_ng_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_held   <= '0;
            r_nn_sum <= '0;
            r_ng_sum <= '0;
            r_nn_cnt <= '0;
            r_ng_cnt <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_shift  <= '0;
                r_held   <= '0;
                r_nn_sum <= '0;
                r_ng_sum <= '0;
                r_nn_cnt <= '0;
                r_ng_cnt <= '0;
            end else begin
                r_shift  <= n_shift;
                r_held   <= n_held;
                r_nn_sum <= n_nn_sum;
                r_ng_sum <= n_ng_sum;
                r_nn_cnt <= n_nn_cnt;
                r_ng_cnt <= n_ng_cnt;
            end
        end
    end

endmodule

// ----- rtl/core/sbpms_queue.sv -----
module sbpms_queue #(
    parameter int WIDTH = $bits(sbpms_pkg::t_word_cmd)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/sbpms_div.sv -----
module sbpms_div #(
    parameter int unsigned MAX_ELEMENTS = sbpms_pkg::MAX_ELEMENTS_DEF,
    localparam int CNT_W  = sbpms_pkg::cnt_width(MAX_ELEMENTS),
    localparam int SUM_W  = sbpms_pkg::sum_width(MAX_ELEMENTS),
    localparam int STEP_W = $clog2(SUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem, r_div;

    logic [CNT_W:0]    rem_sh, diff;
    logic              ge;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= STEP_W'(SUM_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_rem  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/sbpms_back.sv -----
module sbpms_back #(
    parameter int unsigned MAX_ELEMENTS = sbpms_pkg::MAX_ELEMENTS_DEF,
    localparam int CNT_W = sbpms_pkg::cnt_width(MAX_ELEMENTS),
    localparam int SUM_W = sbpms_pkg::sum_width(MAX_ELEMENTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_scaling_en,
    input  logic                 i_empty,
    input  sbpms_pkg::t_word_cmd i_cmd,
    input  logic [SUM_W-1:0]     i_nn_sum,
    input  logic [SUM_W-1:0]     i_ng_sum,
    input  logic [CNT_W-1:0]     i_nn_cnt,
    input  logic [CNT_W-1:0]     i_ng_cnt,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [31:0]          o_word,
    output logic signed [31:0]   o_scale,
    output logic                 o_empty_group,
    output logic                 o_last_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_POS,
        S_DIV_NEG
    } t_state;

    t_state           r_state;
    logic             r_valid, r_en, r_nn_zero, r_ng_zero;
    logic [1:0]       r_kind;
    logic [31:0]      r_word, r_scale;
    logic             r_empty, r_lastr;
    logic [SUM_W-1:0] r_ng_sum;
    logic [CNT_W-1:0] r_ng_cnt;

    logic             out_free, div_start, div_done, out_load;
    logic [SUM_W-1:0] div_dividend, div_quo;
    logic [CNT_W-1:0] div_divisor;
    logic [31:0]      quo32, pos_scale, neg_scale;
    logic             pos_empty, neg_empty;

    assign out_free = !r_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty && out_free;

    // output register takes a new word this cycle
    assign out_load = o_pop || (((r_state == S_DIV_POS) || (r_state == S_DIV_NEG)) &&
                                div_done && out_free);

    // nonnegative mean starts at the end word, negative mean after it is handed on
    always_comb begin
        div_start    = 1'b0;
        div_dividend = i_nn_sum;
        div_divisor  = i_nn_cnt;
        if (r_state == S_IDLE) begin
            div_start = o_pop && i_cmd.is_end;
        end else if (r_state == S_DIV_POS) begin
            div_start    = div_done && out_free;
            div_dividend = r_ng_sum;
            div_divisor  = r_ng_cnt;
        end
    end

    sbpms_div #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign quo32 = div_quo[31:0];

    always_comb begin
        pos_empty = 1'b0;
        neg_empty = 1'b0;
        priority if (!r_en) begin
            pos_scale = sbpms_pkg::PLUS_ONE;
        end else if (r_nn_zero) begin
            pos_scale = '0;
            pos_empty = 1'b1;
        end else begin
            pos_scale = quo32;
        end
        priority if (!r_en) begin
            neg_scale = sbpms_pkg::MINUS_ONE;
        end else if (r_ng_zero) begin
            neg_scale = '0;
            neg_empty = 1'b1;
        end else begin
            neg_scale = 32'd0 - quo32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_kind  <= sbpms_pkg::KIND_WORD;
                        r_word  <= i_cmd.word;
                        r_scale <= '0;
                        r_empty <= 1'b0;
                        r_lastr <= 1'b0;
                        if (i_cmd.is_end) begin
                            r_ng_sum  <= i_ng_sum;
                            r_ng_cnt  <= i_ng_cnt;
                            r_en      <= i_scaling_en;
                            r_nn_zero <= (i_nn_cnt == '0);
                            r_ng_zero <= (i_ng_cnt == '0);
                            r_state   <= S_DIV_POS;
                        end
                    end
                end
                S_DIV_POS: begin
                    if (div_done && out_free) begin
                        r_kind  <= sbpms_pkg::KIND_POS;
                        r_word  <= '0;
                        r_scale <= pos_scale;
                        r_empty <= pos_empty;
                        r_lastr <= 1'b0;
                        r_state <= S_DIV_NEG;
                    end
                end
                S_DIV_NEG: begin
                    if (div_done && out_free) begin
                        r_kind  <= sbpms_pkg::KIND_NEG;
                        r_word  <= '0;
                        r_scale <= neg_scale;
                        r_empty <= neg_empty;
                        r_lastr <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_word        = r_word;
    assign o_scale       = $signed(r_scale);
    assign o_empty_group = r_empty;
    assign o_last_result = r_lastr;

endmodule

// ----- rtl/core/sign_bit_packer_mean_scaler.sv -----
// channel   direction  handshake                    payload
// in        sink       i_in_valid / o_in_stall      i_sample, i_last
// out       source     o_out_valid / i_out_stall    o_kind, o_packed_word, o_scale,
//                                                   o_empty_group, o_last_result
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_data (scaling enable)
//
// the front takes one element a cycle while the two-entry word queue has room
// each full word, and the closing word of a tensor, is one queue entry
// a tensor end keeps the back busy for two serial divisions, nonnegative mean then
//   negative mean, and the back pops no queue entry until both are handed on
// synchronous active-low reset clears the accumulators, queue and output valid flag;
//   scaling enable resets to on
// either side may stall on its own: the queue and output register decouple them
module sign_bit_packer_mean_scaler #(
    parameter int unsigned MAX_ELEMENTS = sbpms_pkg::MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // element input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sample,
    input  logic               i_last,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_packed_word,
    output logic signed [31:0] o_scale,
    output logic               o_empty_group,
    output logic               o_last_result,
    // configuration word
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    localparam int CNT_W = sbpms_pkg::cnt_width(MAX_ELEMENTS);
    localparam int SUM_W = sbpms_pkg::sum_width(MAX_ELEMENTS);
    localparam int CMD_W = $bits(sbpms_pkg::t_word_cmd);
    localparam int Q_W   = CMD_W + 2 * SUM_W + 2 * CNT_W;

    logic                 r_scaling_en;

    // front to queue
    logic                 f_push;
    sbpms_pkg::t_word_cmd f_cmd;
    logic [SUM_W-1:0]     f_nn_sum, f_ng_sum;
    logic [CNT_W-1:0]     f_nn_cnt, f_ng_cnt;

    // queue to back
    logic [Q_W-1:0]       q_wdata, q_rdata;
    logic                 q_empty, q_full, q_pop;
    sbpms_pkg::t_word_cmd b_cmd;
    logic [SUM_W-1:0]     b_nn_sum, b_ng_sum;
    logic [CNT_W-1:0]     b_nn_cnt, b_ng_cnt;

    // the user must write configuration only while idle; the block has no check for it, so no hold-off
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaling_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_scaling_en <= i_cfg_data;
        end
    end

    // element stalls only on a full queue
    assign o_in_stall = q_full;

    sbpms_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_full   (q_full),
        .o_push   (f_push),
        .o_cmd    (f_cmd),
        .o_nn_sum (f_nn_sum),
        .o_ng_sum (f_ng_sum),
        .o_nn_cnt (f_nn_cnt),
        .o_ng_cnt (f_ng_cnt)
    );

    // sums and counts ride along; the back only looks at them on the end word
    assign q_wdata = {f_cmd, f_nn_sum, f_ng_sum, f_nn_cnt, f_ng_cnt};

    sbpms_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_cmd, b_nn_sum, b_ng_sum, b_nn_cnt, b_ng_cnt} = q_rdata;

    sbpms_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scaling_en  (r_scaling_en),
        .i_empty       (q_empty),
        .i_cmd         (b_cmd),
        .i_nn_sum      (b_nn_sum),
        .i_ng_sum      (b_ng_sum),
        .i_nn_cnt      (b_nn_cnt),
        .i_ng_cnt      (b_ng_cnt),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_kind        (o_kind),
        .o_word        (o_packed_word),
        .o_scale       (o_scale),
        .o_empty_group (o_empty_group),
        .o_last_result (o_last_result)
    );

endmodule
